/* rtl/bcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click detector package
// Shared types and constants for the click detector state machine and its
// wrapper.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int LIMIT_W     = 24;
  localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_PRESS_HIGH   = 3'd1,
    REG_DEBOUNCE     = 3'd2,
    REG_SINGLE_CLICK = 3'd3,
    REG_LONG_CLICK   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE         = 4'd0,
    ST_DEBOUNCE     = 4'd1,
    ST_PRESSED      = 4'd2,
    ST_CLICK_UP     = 4'd3,
    ST_CLICK_IDLE   = 4'd4,
    ST_SINGLE       = 4'd5,
    ST_DBL_DEBOUNCE = 4'd6,
    ST_DOUBLE       = 4'd7,
    ST_LONG         = 4'd8,
    ST_OTHER_UP     = 4'd9
  } state_t;

  typedef struct packed {
    logic               enable;
    logic               press_high;
    logic [LIMIT_W-1:0] debounce_ticks;
    logic [LIMIT_W-1:0] single_ticks;
    logic [LIMIT_W-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic single_click;
    logic double_click;
    logic long_click;
    logic released;
  } evt_t;

endpackage

/* rtl/bcd_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click detector state machine
// Holds the click state and the elapsed tick counter, and advances them by
// one tick when step is high while enabled, unless idle with the button up.
// ----------------------------------------------------------------------------
module bcd_fsm
  import bcd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  logic   level,
  input  cfg_t   cfg,
  output logic   pressed,
  output state_t state_after,
  output evt_t   ev
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  state_t                 state;
  state_t                 state_next;
  logic [COUNT_WIDTH-1:0] elapsed;
  logic [COUNT_WIDTH-1:0] elapsed_sat;
  logic [CMP_W-1:0]       d_ext;
  logic                   run;
  logic                   change;
  logic                   hit_debounce;
  logic                   hit_single;
  logic                   hit_long;

  always_comb begin
    pressed      = level ^ ~cfg.press_high;
    run          = cfg.enable && !(state == ST_IDLE && !pressed);
    elapsed_sat  = (elapsed == CNT_MAX) ? elapsed : elapsed + 1'b1;
    d_ext        = CMP_W'(elapsed_sat);
    hit_debounce = d_ext >= CMP_W'(cfg.debounce_ticks);
    hit_single   = d_ext >= CMP_W'(cfg.single_ticks);
    hit_long     = d_ext >= CMP_W'(cfg.long_ticks);

    case (state)
      ST_IDLE:         state_next = pressed ? ST_DEBOUNCE : ST_IDLE;
      ST_DEBOUNCE:     state_next = !pressed ? ST_IDLE :
                                    (hit_debounce ? ST_PRESSED : ST_DEBOUNCE);
      ST_PRESSED:      state_next = !pressed ? ST_CLICK_UP :
                                    (hit_long ? ST_LONG : ST_PRESSED);
      ST_CLICK_UP:     state_next = ST_CLICK_IDLE;
      ST_CLICK_IDLE:   state_next = pressed ? ST_DBL_DEBOUNCE :
                                    (hit_single ? ST_SINGLE : ST_CLICK_IDLE);
      ST_SINGLE:       state_next = ST_IDLE;
      ST_DBL_DEBOUNCE: state_next = !pressed ? ST_CLICK_IDLE :
                                    (hit_debounce ? ST_DOUBLE : ST_DBL_DEBOUNCE);
      ST_DOUBLE:       state_next = pressed ? ST_DOUBLE : ST_OTHER_UP;
      ST_LONG:         state_next = pressed ? ST_LONG : ST_OTHER_UP;
      default:         state_next = ST_IDLE;
    endcase

    change      = run && (state_next != state);
    state_after = run ? state_next : state;

    ev.single_click = change && (state_next == ST_SINGLE);
    ev.double_click = change && (state_next == ST_DOUBLE);
    ev.long_click   = change && (state_next == ST_LONG);
    ev.released     = change && (state_next == ST_SINGLE || state_next == ST_OTHER_UP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      elapsed <= '0;
    end else if (step && run) begin
      state   <= state_next;
      // The counter restarts on every state change and saturates otherwise.
      elapsed <= change ? '0 : elapsed_sat;
    end
  end

`ifndef SYNTHESIS
  a_hold_when_stopped: assert property (@(posedge clk) disable iff (rst)
    !rst && !(step && cfg.enable) |=> $stable(state) && $stable(elapsed))
    else $error("state or counter moved without an active tick");

  a_restart_on_change: assert property (@(posedge clk) disable iff (rst)
    step && change |=> elapsed == '0)
    else $error("elapsed counter not restarted on a state change");

  a_double_source: assert property (@(posedge clk) disable iff (rst)
    ev.double_click |-> state == ST_DBL_DEBOUNCE && pressed)
    else $error("double click entered from a wrong state");

  a_long_source: assert property (@(posedge clk) disable iff (rst)
    ev.long_click |-> state == ST_PRESSED && pressed)
    else $error("long click entered from a wrong state");
`endif

endmodule

/* rtl/button_click_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click detector unit
// Debounced single, double and long click detection on a sampled pin.
// ----------------------------------------------------------------------------
// Each accepted item is one sample tick of the raw pin level and yields
// exactly one result item: an input register holds the sample, the state
// machine updates as the item moves on from it and the result register
// presents its events, the state after the tick and the polarity-corrected
// level. One item can be accepted every cycle; a stalled result holds the
// input side only once the input register is also full.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data,
// which is always ready; indexes beyond the register list are ignored.
module button_click_detector_unit
  import bcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic                 pin_level,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 single_click,
  output logic                 double_click,
  output logic                 long_click,
  output logic                 released,
  output logic [3:0]           current_state,
  output logic                 is_pressed,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t   cfg;
  logic   s1_valid;
  logic   s1_level;
  logic   out_load;
  logic   advance;
  logic   pressed;
  state_t state_after;
  evt_t   ev;

  assign cfg_ready    = 1'b1;
  assign out_load     = !result_valid || !result_stall;
  assign advance      = s1_valid && out_load;
  assign sample_stall = s1_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:       cfg.enable         <= cfg_data[0];
        REG_PRESS_HIGH:   cfg.press_high     <= cfg_data[0];
        REG_DEBOUNCE:     cfg.debounce_ticks <= cfg_data[LIMIT_W-1:0];
        REG_SINGLE_CLICK: cfg.single_ticks   <= cfg_data[LIMIT_W-1:0];
        REG_LONG_CLICK:   cfg.long_ticks     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!sample_stall) begin
        s1_valid <= sample_valid;
      end
      if (out_load) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_level <= pin_level;
    end
    if (advance) begin
      single_click  <= ev.single_click;
      double_click  <= ev.double_click;
      long_click    <= ev.long_click;
      released      <= ev.released;
      current_state <= state_after;
      is_pressed    <= pressed;
    end
  end

  bcd_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .level       (s1_level),
    .cfg         (cfg),
    .pressed     (pressed),
    .state_after (state_after),
    .ev          (ev)
  );

endmodule
